/* rtl/core/rbps_pkg.sv */
`default_nettype none
package rbps_pkg;

	localparam int COORD_W   = 24;
	localparam int HEAD_W    = 16;
	localparam int COUNT_W   = 7;
	localparam int INDEX_W   = 6;
	localparam int DELTA_W   = 25;
	localparam int UNIT_W    = 16;
	localparam int CP_W      = 44;
	localparam int CORDIC_W  = 34;
	localparam int CORDIC_STEPS = 18;
	localparam int T_W       = 17;
	localparam int WGT_W     = 21;
	localparam int ACC_W     = 66;

	localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 7'd32;

	// chord fractions in Q0.16, push distances doubled to Q16 mm scale
	localparam logic signed [17:0] FRAC_NEAR = 18'sd18350;
	localparam logic signed [17:0] FRAC_FAR  = 18'sd47186;
	localparam logic signed [17:0] PUSH_N1   = 18'sd2200;
	localparam logic signed [17:0] PUSH_N2   = 18'sd900;
	localparam logic signed [17:0] PUSH_PX1  = 18'sd700;
	localparam logic signed [17:0] PUSH_PY1  = 18'sd500;
	localparam logic signed [17:0] PUSH_PX2  = 18'sd400;
	localparam logic signed [17:0] PUSH_PY2  = 18'sd200;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic [3:0][CP_W-1:0] cx;
		logic [3:0][CP_W-1:0] cy;
		logic [COUNT_W-1:0]   n;
	} job_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [INDEX_W-1:0]        index;
		logic                      last;
	} res_t;

	function automatic logic signed [CORDIC_W-1:0] atan_entry(input logic [4:0] i);
		logic signed [CORDIC_W-1:0] a;
		case (i)
			5'd0:  a = 34'sh020000000;
			5'd1:  a = 34'sh012E4051E;
			5'd2:  a = 34'sh009FB385B;
			5'd3:  a = 34'sh0051111D4;
			5'd4:  a = 34'sh0028B0D43;
			5'd5:  a = 34'sh00145D7E1;
			5'd6:  a = 34'sh000A2F61E;
			5'd7:  a = 34'sh000517C55;
			5'd8:  a = 34'sh00028BE53;
			5'd9:  a = 34'sh000145F2F;
			5'd10: a = 34'sh0000A2F98;
			5'd11: a = 34'sh0000517CC;
			5'd12: a = 34'sh000028BE6;
			5'd13: a = 34'sh0000145F3;
			5'd14: a = 34'sh000000A2FA;
			5'd15: a = 34'sh00000517D;
			5'd16: a = 34'sh0000028BE;
			5'd17: a = 34'sh00000145F;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/rbps_fifo.sv */
`default_nettype none
module rbps_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire logic [W-1:0] din,
	input  wire logic         pop,
	output logic              empty,
	output logic [W-1:0]      dout
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= din;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/rbps_front.sv */
`default_nettype none
module rbps_front #(
	parameter int MAX_POINTS = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic signed [rbps_pkg::COORD_W-1:0] start_x,
	input  wire logic signed [rbps_pkg::COORD_W-1:0] start_y,
	input  wire logic signed [rbps_pkg::COORD_W-1:0] goal_x,
	input  wire logic signed [rbps_pkg::COORD_W-1:0] goal_y,
	input  wire logic [rbps_pkg::HEAD_W-1:0]         slot_heading,
	input  wire logic [rbps_pkg::COUNT_W-1:0]        count,
	output logic                                     job_push,
	input  wire logic                                job_full,
	output rbps_pkg::job_t                           job
);
	import rbps_pkg::*;

	localparam logic [3:0] F_IDLE = 4'd0;
	localparam logic [3:0] F_SQX  = 4'd1;
	localparam logic [3:0] F_SQY  = 4'd2;
	localparam logic [3:0] F_SQRT = 4'd3;
	localparam logic [3:0] F_DSET = 4'd4;
	localparam logic [3:0] F_DIV  = 4'd5;
	localparam logic [3:0] F_VEC  = 4'd6;
	localparam logic [3:0] F_CP1  = 4'd7;
	localparam logic [3:0] F_CP2  = 4'd8;
	localparam logic [3:0] F_PUSH = 4'd9;

	function automatic logic signed [CP_W-1:0] ctrl_pt(
		input logic signed [COORD_W-1:0] s,
		input logic signed [DELTA_W-1:0] d,
		input logic signed [UNIT_W-1:0]  nrm,
		input logic signed [UNIT_W-1:0]  perp,
		input logic signed [17:0]        fr,
		input logic signed [17:0]        kn,
		input logic signed [17:0]        kp
	);
		logic signed [CP_W-1:0] base;
		base = {{(CP_W-COORD_W-16){s[COORD_W-1]}}, s, 16'b0};
		return base + CP_W'(d) * CP_W'(fr) + CP_W'(nrm) * CP_W'(kn) + CP_W'(perp) * CP_W'(kp);
	endfunction

	function automatic logic signed [UNIT_W-1:0] sat16(input logic signed [CORDIC_W-1:0] v);
		logic signed [UNIT_W-1:0] r;
		if (v > 34'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -34'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[UNIT_W-1:0];
		end
		return r;
	endfunction

	logic [3:0] state_q;
	logic [4:0] ci_q, k_q;

	logic signed [COORD_W-1:0]  sx_q, sy_q;
	logic signed [DELTA_W-1:0]  dx_q, dy_q;
	logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
	logic                       flip_q;
	logic [49:0]                v_q;
	logic [27:0]                rem_q;
	logic [24:0]                root_q;
	logic [41:0]                numx_q, numy_q, dsh_q;
	logic [15:0]                qx_q, qy_q;
	logic signed [UNIT_W-1:0]   px_q, py_q, nx_q, ny_q;
	job_t                       job_q;

	logic                       accept, degen;
	logic signed [DELTA_W-1:0]  dx_c, dy_c;
	logic [COUNT_W-1:0]         n_c;
	logic signed [CORDIC_W-1:0] z_c;
	logic                       flip_c;
	logic signed [2*DELTA_W-1:0] sq_c;
	logic [27:0]                rem_n, trial;
	logic [DELTA_W-1:0]         adx, ady;
	logic signed [CORDIC_W-1:0] xs, ys, xf, yf;
	logic signed [UNIT_W-1:0]   cs_c, sn_c;
	logic signed [UNIT_W:0]     nsn;

	assign full     = (state_q != F_IDLE);
	assign accept   = push && !full;
	assign job_push = (state_q == F_PUSH);
	assign job      = job_q;

	assign dx_c  = DELTA_W'(goal_x) - DELTA_W'(start_x);
	assign dy_c  = DELTA_W'(goal_y) - DELTA_W'(start_y);
	assign degen = (dx_c == '0) && (dy_c == '0);

	always_comb begin
		if (count == '0) begin
			n_c = COUNT_W'(1);
		end else if (count > COUNT_W'(MAX_POINTS)) begin
			n_c = COUNT_W'(MAX_POINTS);
		end else begin
			n_c = count;
		end
	end

	// fold the heading into [-quarter, quarter) before the rotation
	always_comb begin
		z_c    = $signed({2'b00, slot_heading, 16'b0});
		flip_c = 1'b0;
		case (slot_heading[15:14])
			2'b01, 2'b10: begin
				z_c    = $signed({2'b00, slot_heading, 16'b0}) - 34'sd2147483648;
				flip_c = 1'b1;
			end
			2'b11: begin
				z_c = $signed({2'b00, slot_heading, 16'b0}) - 34'sd4294967296;
			end
			default: ;
		endcase
	end

	assign sq_c  = (state_q == F_SQX) ? dx_q * dx_q : dy_q * dy_q;
	assign rem_n = {rem_q[25:0], v_q[49:48]};
	assign trial = {1'b0, root_q, 2'b01};
	assign adx   = dx_q[DELTA_W-1] ? DELTA_W'(-dx_q) : DELTA_W'(dx_q);
	assign ady   = dy_q[DELTA_W-1] ? DELTA_W'(-dy_q) : DELTA_W'(dy_q);
	assign xs    = x_q >>> ci_q;
	assign ys    = y_q >>> ci_q;
	assign xf    = flip_q ? -x_q : x_q;
	assign yf    = flip_q ? -y_q : y_q;
	assign cs_c  = sat16((xf + 34'sd16384) >>> 15);
	assign sn_c  = sat16((yf + 34'sd16384) >>> 15);
	assign nsn   = -{sn_c[UNIT_W-1], sn_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			ci_q    <= 5'(CORDIC_STEPS);
			k_q     <= '0;
		end else begin
			if (ci_q != 5'(CORDIC_STEPS)) begin
				ci_q <= ci_q + 1'b1;
			end
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (degen) begin
							state_q <= F_PUSH;
						end else begin
							state_q <= F_SQX;
							ci_q    <= '0;
						end
					end
				end
				F_SQX: state_q <= F_SQY;
				F_SQY: begin
					state_q <= F_SQRT;
					k_q     <= '0;
				end
				F_SQRT: begin
					k_q <= k_q + 1'b1;
					if (k_q == 5'd24) begin
						state_q <= F_DSET;
					end
				end
				F_DSET: begin
					state_q <= F_DIV;
					k_q     <= '0;
				end
				F_DIV: begin
					k_q <= k_q + 1'b1;
					if (k_q == 5'd15) begin
						state_q <= F_VEC;
					end
				end
				F_VEC:  state_q <= F_CP1;
				F_CP1:  state_q <= F_CP2;
				F_CP2:  state_q <= F_PUSH;
				F_PUSH: begin
					if (!job_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ci_q != 5'(CORDIC_STEPS)) begin
			if (!z_q[CORDIC_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_entry(ci_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_entry(ci_q);
			end
		end
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					sx_q   <= start_x;
					sy_q   <= start_y;
					dx_q   <= dx_c;
					dy_q   <= dy_c;
					x_q    <= CORDIC_GAIN;
					y_q    <= '0;
					z_q    <= z_c;
					flip_q <= flip_c;
					job_q.cx[1] <= '0;
					job_q.cx[2] <= '0;
					job_q.cy[1] <= '0;
					job_q.cy[2] <= '0;
					job_q.cx[3] <= {{(CP_W-COORD_W-16){goal_x[COORD_W-1]}}, goal_x, 16'b0};
					job_q.cy[3] <= {{(CP_W-COORD_W-16){goal_y[COORD_W-1]}}, goal_y, 16'b0};
					if (degen) begin
						// one point at t = 0: the goal sits in the first slot
						job_q.cx[0] <= {{(CP_W-COORD_W-16){goal_x[COORD_W-1]}}, goal_x, 16'b0};
						job_q.cy[0] <= {{(CP_W-COORD_W-16){goal_y[COORD_W-1]}}, goal_y, 16'b0};
						job_q.n     <= COUNT_W'(1);
					end else begin
						job_q.cx[0] <= {{(CP_W-COORD_W-16){start_x[COORD_W-1]}}, start_x, 16'b0};
						job_q.cy[0] <= {{(CP_W-COORD_W-16){start_y[COORD_W-1]}}, start_y, 16'b0};
						job_q.n     <= n_c;
					end
				end
			end
			F_SQX: v_q <= 50'(unsigned'(sq_c));
			F_SQY: begin
				v_q    <= v_q + 50'(unsigned'(sq_c));
				rem_q  <= '0;
				root_q <= '0;
			end
			F_SQRT: begin
				v_q <= {v_q[47:0], 2'b00};
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[23:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[23:0], 1'b0};
				end
			end
			F_DSET: begin
				numx_q <= {1'b0, ady, 16'b0} + 42'(root_q);
				numy_q <= {1'b0, adx, 16'b0} + 42'(root_q);
				dsh_q  <= {1'b0, root_q, 16'b0};
				qx_q   <= '0;
				qy_q   <= '0;
			end
			F_DIV: begin
				dsh_q <= dsh_q >> 1;
				if (numx_q >= dsh_q) begin
					numx_q <= numx_q - dsh_q;
					qx_q   <= {qx_q[14:0], 1'b1};
				end else begin
					qx_q <= {qx_q[14:0], 1'b0};
				end
				if (numy_q >= dsh_q) begin
					numy_q <= numy_q - dsh_q;
					qy_q   <= {qy_q[14:0], 1'b1};
				end else begin
					qy_q <= {qy_q[14:0], 1'b0};
				end
			end
			F_VEC: begin
				// perpendicular is (-dy, dx) / L; quotient tops out at one
				if (!dy_q[DELTA_W-1] && dy_q != '0) begin
					px_q <= UNIT_W'(-{1'b0, qx_q});
				end else begin
					px_q <= qx_q[15] ? 16'sh7FFF : $signed(qx_q);
				end
				if (dx_q[DELTA_W-1]) begin
					py_q <= UNIT_W'(-{1'b0, qy_q});
				end else begin
					py_q <= qy_q[15] ? 16'sh7FFF : $signed(qy_q);
				end
				nx_q <= (nsn > 17'sd32767) ? 16'sh7FFF : nsn[UNIT_W-1:0];
				ny_q <= cs_c;
			end
			F_CP1: begin
				job_q.cx[1] <= ctrl_pt(sx_q, dx_q, nx_q, px_q, FRAC_NEAR, PUSH_N1, PUSH_PX1);
				job_q.cy[1] <= ctrl_pt(sy_q, dy_q, ny_q, py_q, FRAC_NEAR, PUSH_N1, PUSH_PY1);
			end
			F_CP2: begin
				job_q.cx[2] <= ctrl_pt(sx_q, dx_q, nx_q, px_q, FRAC_FAR, PUSH_N2, PUSH_PX2);
				job_q.cy[2] <= ctrl_pt(sy_q, dy_q, ny_q, py_q, FRAC_FAR, PUSH_N2, PUSH_PY2);
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/core/rbps_back.sv */
`default_nettype none
module rbps_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            job_empty,
	output logic                 job_pop,
	input  wire rbps_pkg::job_t  job,
	output logic                 res_push,
	input  wire logic            res_full,
	output rbps_pkg::res_t       res
);
	import rbps_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_DIV  = 3'd1;
	localparam logic [2:0] B_WGT  = 3'd2;
	localparam logic [2:0] B_MAC  = 3'd3;
	localparam logic [2:0] B_OUT  = 3'd4;

	localparam logic [3:0] W_UU = 4'd0;
	localparam logic [3:0] W_TT = 4'd1;
	localparam logic [3:0] W_B0 = 4'd2;
	localparam logic [3:0] W_B1 = 4'd3;
	localparam logic [3:0] W_B2 = 4'd4;
	localparam logic [3:0] W_B3 = 4'd5;

	localparam logic signed [ACC_W-1:0] COORD_MAX = 66'sd8388607;
	localparam logic signed [ACC_W-1:0] COORD_MIN = -66'sd8388608;

	logic [2:0]         state_q;
	logic [3:0]         step_q;
	logic [4:0]         dk_q;
	logic [COUNT_W-1:0] i_q;
	job_t               job_q;
	logic [7:0]         d_q, tr_q;
	logic [17:0]        drem_q;
	logic [23:0]        dsh_q;
	logic [T_W-1:0]     qs_q, tq_q;
	logic [33:0]        uu_q, tt_q;
	logic [WGT_W-1:0]   w_q [4];
	logic signed [ACC_W-1:0] ax_q, ay_q;

	logic [COUNT_W-1:0] den;
	logic [T_W-1:0]     u;
	logic [33:0]        ma;
	logic [T_W-1:0]     mb;
	logic [50:0]        mprod;
	logic [52:0]        bw, bwr;
	logic [1:0]         mk;
	logic [CP_W-1:0]    elem;
	logic signed [22:0] mop;
	logic signed [44:0] mac;
	logic signed [ACC_W-1:0] term, rx, ry;
	logic [8:0]         tr_sum;
	logic               last, advance;

	assign job_pop  = (state_q == B_IDLE) && !job_empty;
	assign res_push = (state_q == B_OUT);
	assign last     = (i_q == job_q.n - 1'b1);
	assign advance  = res_push && !res_full;
	assign den      = (job.n <= COUNT_W'(1)) ? COUNT_W'(1) : job.n - 1'b1;
	assign u        = 17'd65536 - tq_q;

	always_comb begin
		ma = {17'b0, u};
		mb = u;
		case (step_q)
			W_UU: begin ma = {17'b0, u};    mb = u;    end
			W_TT: begin ma = {17'b0, tq_q}; mb = tq_q; end
			W_B0: begin ma = uu_q;          mb = u;    end
			W_B1: begin ma = uu_q;          mb = tq_q; end
			W_B2: begin ma = tt_q;          mb = u;    end
			W_B3: begin ma = tt_q;          mb = tq_q; end
			default: ;
		endcase
	end

	assign mprod = ma * mb;
	assign bw    = (step_q == W_B1 || step_q == W_B2) ?
	               {2'b0, mprod} + {1'b0, mprod, 1'b0} : {2'b0, mprod};
	assign bwr   = bw + 53'd134217728;

	// step code: weight index, then coordinate, then low/high half of the control point
	assign mk   = step_q[3:2];
	assign elem = step_q[1] ? job_q.cy[mk] : job_q.cx[mk];
	assign mop  = step_q[0] ? $signed({elem[CP_W-1], elem[CP_W-1:22]}) : $signed({1'b0, elem[21:0]});
	assign mac  = mop * $signed({1'b0, w_q[mk]});
	assign term = step_q[0] ? (ACC_W'(mac) <<< 22) : ACC_W'(mac);

	assign rx = (ax_q + 66'sd34359738368) >>> 36;
	assign ry = (ay_q + 66'sd34359738368) >>> 36;
	assign res.x = (rx > COORD_MAX) ? COORD_MAX[COORD_W-1:0] :
	               (rx < COORD_MIN) ? COORD_MIN[COORD_W-1:0] : rx[COORD_W-1:0];
	assign res.y = (ry > COORD_MAX) ? COORD_MAX[COORD_W-1:0] :
	               (ry < COORD_MIN) ? COORD_MIN[COORD_W-1:0] : ry[COORD_W-1:0];
	assign res.index = i_q[INDEX_W-1:0];
	assign res.last  = last;

	assign tr_sum = {1'b0, tr_q} + 9'(drem_q[7:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q  <= '0;
			dk_q    <= '0;
			i_q     <= '0;
			tq_q    <= '0;
			tr_q    <= '0;
			d_q     <= 8'd2;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (job_pop) begin
						state_q <= B_DIV;
						dk_q    <= '0;
						i_q     <= '0;
						tq_q    <= '0;
						tr_q    <= 8'(den);
						d_q     <= {den, 1'b0};
					end
				end
				B_DIV: begin
					dk_q <= dk_q + 1'b1;
					if (dk_q == 5'd16) begin
						state_q <= B_WGT;
						step_q  <= W_UU;
					end
				end
				B_WGT: begin
					step_q <= step_q + 1'b1;
					if (step_q == W_B3) begin
						state_q <= B_MAC;
						step_q  <= '0;
					end
				end
				B_MAC: begin
					step_q <= step_q + 1'b1;
					if (step_q == 4'd15) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (advance) begin
						if (last) begin
							state_q <= B_IDLE;
						end else begin
							// step t by 1/(n-1): quotient plus remainder carry
							state_q <= B_WGT;
							step_q  <= W_UU;
							i_q     <= i_q + 1'b1;
							if (tr_sum >= {1'b0, d_q}) begin
								tq_q <= tq_q + qs_q + 1'b1;
								tr_q <= 8'(tr_sum - {1'b0, d_q});
							end else begin
								tq_q <= tq_q + qs_q;
								tr_q <= tr_sum[7:0];
							end
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (job_pop) begin
					job_q  <= job;
					drem_q <= 18'd131072;
					dsh_q  <= {9'b0, den, 8'b0} << 9;
					qs_q   <= '0;
				end
			end
			B_DIV: begin
				dsh_q <= dsh_q >> 1;
				if ({6'b0, drem_q} >= dsh_q) begin
					drem_q <= drem_q - dsh_q[17:0];
					qs_q   <= {qs_q[T_W-2:0], 1'b1};
				end else begin
					qs_q <= {qs_q[T_W-2:0], 1'b0};
				end
			end
			B_WGT: begin
				case (step_q)
					W_UU: uu_q <= mprod[33:0];
					W_TT: tt_q <= mprod[33:0];
					W_B0: w_q[0] <= bwr[48:28];
					W_B1: w_q[1] <= bwr[48:28];
					W_B2: w_q[2] <= bwr[48:28];
					W_B3: begin
						w_q[3] <= bwr[48:28];
						ax_q   <= '0;
						ay_q   <= '0;
					end
					default: ;
				endcase
			end
			B_MAC: begin
				if (step_q[1]) begin
					ay_q <= ay_q + term;
				end else begin
					ax_q <= ax_q + term;
				end
			end
			default: ;
		endcase
	end

	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last) |=> (state_q == B_IDLE))
		else $error("job did not end after its last point");

	a_t_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(tq_q <= 17'd65536))
		else $error("curve parameter ran past one");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WGT || state_q == B_MAC || state_q == B_OUT) |-> (tr_q < d_q))
		else $error("parameter remainder not reduced");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> (state_q == B_DIV && dk_q == 5'd0))
		else $error("job fetch did not start the step division");
endmodule
`default_nettype wire

/* rtl/core/reverse_bezier_path_sampler_core.sv */
`default_nettype none
// Channel   Handshake                 Payload
// request   push / full               start_x, start_y, goal_x, goal_y, slot_heading
// config    cfg_valid / cfg_ready     cfg_data (sample_count)
// result    pop / empty               point_x, point_y, point_index, is_last
//
// The front holds off new requests while it works on one: squares, a 25-step square root,
// a 16-step divide for the chord perpendicular, with an 18-step CORDIC alongside.
// The back runs the t step divide once per request, then for each point runs
// 6 weight multiplies, 16 control point multiply-accumulates and one output.
// Two jobs queue between the front and the back.
// Reset clears sample_count to 32 and empties both queues; a full result queue
// stalls the back only, and the front keeps taking requests until the job queue fills.
module reverse_bezier_path_sampler_core #(
	parameter int MAX_POINTS = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic signed [rbps_pkg::COORD_W-1:0] start_x,
	input  wire logic signed [rbps_pkg::COORD_W-1:0] start_y,
	input  wire logic signed [rbps_pkg::COORD_W-1:0] goal_x,
	input  wire logic signed [rbps_pkg::COORD_W-1:0] goal_y,
	input  wire logic [rbps_pkg::HEAD_W-1:0]         slot_heading,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rbps_pkg::COUNT_W-1:0]        cfg_data,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic signed [rbps_pkg::COORD_W-1:0]      point_x,
	output logic signed [rbps_pkg::COORD_W-1:0]      point_y,
	output logic [rbps_pkg::INDEX_W-1:0]             point_index,
	output logic                                     is_last
);
	import rbps_pkg::*;

	logic [COUNT_W-1:0] sample_count_q;
	logic               job_push, job_full, job_empty, job_pop;
	job_t               job_in, job_out;
	logic               res_push, res_full;
	res_t               res_in, res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sample_count_q <= cfg_data;
		end
	end

	rbps_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.start_x(start_x), .start_y(start_y),
		.goal_x(goal_x), .goal_y(goal_y),
		.slot_heading(slot_heading),
		.count(sample_count_q),
		.job_push(job_push), .job_full(job_full), .job(job_in)
	);

	rbps_fifo #(.W($bits(job_t)), .DEPTH(2)) u_job_q (
		.clk(clk), .arst_n(arst_n),
		.push(job_push), .full(job_full), .din(job_in),
		.pop(job_pop), .empty(job_empty), .dout(job_out)
	);

	rbps_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_empty(job_empty), .job_pop(job_pop), .job(job_out),
		.res_push(res_push), .res_full(res_full), .res(res_in)
	);

	rbps_fifo #(.W($bits(res_t)), .DEPTH(2)) u_res_q (
		.clk(clk), .arst_n(arst_n),
		.push(res_push), .full(res_full), .din(res_in),
		.pop(pop), .empty(empty), .dout(res_out)
	);

	assign point_x     = res_out.x;
	assign point_y     = res_out.y;
	assign point_index = res_out.index;
	assign is_last     = res_out.last;
endmodule
`default_nettype wire
